### hdl/pts_pkg.sv
// shared types and constants for the point toggle proximity set
`default_nettype none

package pts_pkg;

   // width of the tolerance register, unsigned q15.16
   localparam int TOL_BITS = 31;
   // width of a squared tolerance or a squared axis distance
   localparam int SQ_BITS = 2 * TOL_BITS;
   // width of the sum of three squares
   localparam int SUM_BITS = SQ_BITS + 2;

   localparam logic [TOL_BITS-1:0] TOL_RESET = 31'd65536;

   typedef enum logic [1:0] {
      ACT_APPEND = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_FULL   = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_DONE
   } state_type;

   // status of the distance pipeline toward the sequencer
   typedef struct packed {
      logic busy;
      logic hit;
   } dist_stat_type;

endpackage

`default_nettype wire

### hdl/pts_dist.sv
// three stage proximity test of one stored point against the query point
`default_nettype none

module pts_dist import pts_pkg::*; #(
   parameter int COORD_BITS = 32,
   parameter int AW         = 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   input  wire logic [AW-1:0]           in_idx,
   input  wire logic [3*COORD_BITS-1:0] stored,
   input  wire logic [3*COORD_BITS-1:0] query,
   input  wire logic [TOL_BITS-1:0]     tol,
   input  wire logic [SQ_BITS-1:0]      tol_sq,
   output dist_stat_type                stat,
   output logic [AW-1:0]                hit_idx
);

   localparam int DW = (COORD_BITS + 1 > TOL_BITS) ? COORD_BITS + 1 : TOL_BITS;

   logic [COORD_BITS:0]   se_s [3];
   logic [COORD_BITS:0]   se_q [3];
   logic [COORD_BITS:0]   diff [3];
   logic [COORD_BITS:0]   mag_c [3];
   logic [DW-1:0]         mag_w [3];
   logic [2:0]            far_axis;
   logic [TOL_BITS-1:0]   mag_in [3];
   logic [SQ_BITS-1:0]    sq_in [3];
   logic [SUM_BITS-1:0]   sum;
   logic                  hit;

   logic                  v2_ff, v2_in;
   logic                  far2_ff;
   logic [AW-1:0]         idx2_ff;
   logic [TOL_BITS-1:0]   mag2_ff [3];
   logic                  v3_ff, v3_in;
   logic                  far3_ff;
   logic [AW-1:0]         idx3_ff;
   logic [SQ_BITS-1:0]    sq3_ff [3];

   // stage a: exact axis magnitudes and the per-axis early reject
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         se_s[a]     = {stored[a*COORD_BITS+COORD_BITS-1], stored[a*COORD_BITS +: COORD_BITS]};
         se_q[a]     = {query[a*COORD_BITS+COORD_BITS-1], query[a*COORD_BITS +: COORD_BITS]};
         diff[a]     = se_s[a] - se_q[a];
         mag_c[a]    = diff[a][COORD_BITS] ? (~diff[a] + 1'b1) : diff[a];
         mag_w[a]    = DW'(mag_c[a]);
         far_axis[a] = mag_w[a] > DW'(tol);
         // exact whenever the axis is not far
         mag_in[a]   = mag_w[a][TOL_BITS-1:0];
      end
   end

   // stage m: squares
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         sq_in[a] = SQ_BITS'(mag2_ff[a]) * SQ_BITS'(mag2_ff[a]);
      end
   end

   // stage s: sum and compare against the squared tolerance
   assign sum = SUM_BITS'(sq3_ff[0]) + SUM_BITS'(sq3_ff[1]) + SUM_BITS'(sq3_ff[2]);
   assign hit = v3_ff && !far3_ff && (sum <= SUM_BITS'(tol_sq));

   // a hit flushes whatever follows it
   assign v2_in = in_valid && !hit;
   assign v3_in = v2_ff && !hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      far2_ff <= |far_axis;
      idx2_ff <= in_idx;
      far3_ff <= far2_ff;
      idx3_ff <= idx2_ff;
      for (int a = 0; a < 3; a++) begin
         mag2_ff[a] <= mag_in[a];
         sq3_ff[a]  <= sq_in[a];
      end
   end

   assign stat.busy = v2_ff | v3_ff;
   assign stat.hit  = hit;
   assign hit_idx   = idx3_ff;

endmodule

`default_nettype wire

### hdl/point_toggle_proximity_set.sv
// top level: ordered set of 3d points with proximity toggle
//
// req channel: one transfer per item. req_tuser selects toggle (0) or clear
// (1); req_tdata carries x, y, z as signed q16.16 coordinates. rsp channel:
// one transfer per item with the action in rsp_tuser and the number of
// stored points after the item in rsp_tdata. csr channel: writes the match
// tolerance, accepted in every cycle; write it only while no item is open.
// a toggle scans the stored points one per cycle through a memory with one
// read and one write port and a three stage distance pipeline, then either
// appends the point, reports a full set without storing it, or copies the
// tail down one place, one entry per cycle, after a match. one item is
// worked on at a time: req_tready drops while an item is worked on; a
// finished result waits in the output register while the next item is
// taken, and only the end of that next item waits for rsp_tready.
// reset empties the set and loads the default tolerance of 1.0; the memory
// needs no clearing, as only entries below the count are ever read.
`default_nettype none

module point_toggle_proximity_set import pts_pkg::*; #(
   parameter int CAPACITY   = 256,
   parameter int COORD_BITS = 32
) (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire logic                                          req_tvalid,
   output logic                                               req_tready,
   // coord_x, coord_y, coord_z
   input  wire logic [((3*COORD_BITS+7)/8)*8-1:0]             req_tdata,
   // mode
   input  wire logic [0:0]                                    req_tuser,
   output logic                                               rsp_tvalid,
   input  wire logic                                          rsp_tready,
   // point_count
   output logic [(($clog2(CAPACITY+1)+7)/8)*8-1:0]            rsp_tdata,
   // action
   output logic [1:0]                                         rsp_tuser,
   input  wire logic                                          csr_valid,
   output logic                                               csr_ready,
   input  wire logic [TOL_BITS-1:0]                           csr_data
);

   localparam int AW    = $clog2(CAPACITY);
   localparam int CW    = $clog2(CAPACITY+1);
   localparam int PW    = 3 * COORD_BITS;
   localparam int RSP_W = ((CW + 7) / 8) * 8;

   logic [PW-1:0]        store_ff [CAPACITY];
   logic [PW-1:0]        rd_data_ff;
   logic [AW-1:0]        rd_addr;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [PW-1:0]        wr_data;

   state_type            state_ff, state_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic                 v1_ff, v1_in;
   logic [AW-1:0]        idx1_ff, idx1_in;
   logic [CW-1:0]        count_ff, count_in;
   action_type           act_ff, act_in;
   logic [PW-1:0]        q_ff, q_in;
   logic [TOL_BITS-1:0]  tol_ff, tol_in;
   logic [SQ_BITS-1:0]   tol_sq_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   action_type           rsp_action_ff, rsp_action_in;
   logic [CW-1:0]        rsp_count_ff, rsp_count_in;

   logic                 issue;
   dist_stat_type        dstat;
   logic [AW-1:0]        hit_idx;

   pts_dist #(
      .COORD_BITS (COORD_BITS),
      .AW         (AW)
   ) u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v1_ff && (state_ff == ST_SCAN)),
      .in_idx   (idx1_ff),
      .stored   (rd_data_ff),
      .query    (q_ff),
      .tol      (tol_ff),
      .tol_sq   (tol_sq_ff),
      .stat     (dstat),
      .hit_idx  (hit_idx)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_action_ff;
   assign rsp_tdata  = RSP_W'(rsp_count_ff);

   assign tol_in = (csr_valid && csr_ready) ? csr_data : tol_ff;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      v1_in         = 1'b0;
      idx1_in       = idx_ff[AW-1:0];
      count_in      = count_ff;
      act_in        = act_ff;
      q_in          = q_ff;
      rd_addr       = idx_ff[AW-1:0];
      wr_en         = 1'b0;
      wr_addr       = idx1_ff - AW'(1);
      wr_data       = rd_data_ff;
      issue         = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_action_in = rsp_action_ff;
      rsp_count_in  = rsp_count_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser[0]) begin
                  count_in = '0;
                  act_in   = ACT_CLEAR;
                  state_in = ST_DONE;
               end else begin
                  q_in     = req_tdata[PW-1:0];
                  idx_in   = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            issue = (idx_ff < count_ff) && !dstat.hit;
            v1_in = issue;
            if (issue) begin
               idx_in = idx_ff + CW'(1);
            end
            if (dstat.hit) begin
               // copy the tail down starting just past the match
               idx_in   = CW'(hit_idx) + CW'(1);
               state_in = ST_SHIFT;
            end else if (!issue && !v1_ff && !dstat.busy) begin
               if (count_ff == CW'(CAPACITY)) begin
                  act_in = ACT_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[AW-1:0];
                  wr_data  = q_ff;
                  count_in = count_ff + CW'(1);
                  act_in   = ACT_APPEND;
               end
               state_in = ST_DONE;
            end
         end
         ST_SHIFT: begin
            issue = (idx_ff < count_ff);
            v1_in = issue;
            if (issue) begin
               idx_in = idx_ff + CW'(1);
            end
            // entry read last cycle lands one place lower
            wr_en = v1_ff;
            if (!issue && !v1_ff) begin
               count_in = count_ff - CW'(1);
               act_in   = ACT_REMOVE;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_action_in = act_ff;
               rsp_count_in  = count_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         v1_ff        <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         tol_ff       <= TOL_RESET;
      end else begin
         state_ff     <= state_in;
         v1_ff        <= v1_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         tol_ff       <= tol_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      idx1_ff       <= idx1_in;
      act_ff        <= act_in;
      q_ff          <= q_in;
      rsp_action_ff <= rsp_action_in;
      rsp_count_ff  <= rsp_count_in;
      tol_sq_ff     <= SQ_BITS'(tol_ff) * SQ_BITS'(tol_ff);
   end

endmodule

`default_nettype wire

### hdl/pts_checker.sv
// port level checks for the point toggle proximity set, bound to the top level
`default_nettype none

module pts_checker import pts_pkg::*; #(
   parameter int CAPACITY   = 256
) (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tready,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [(($clog2(CAPACITY+1)+7)/8)*8-1:0] rsp_tdata,
   input wire logic [1:0]                          rsp_tuser
);

   localparam int CW = $clog2(CAPACITY+1);

   logic [CW-1:0] count;
   assign count = rsp_tdata[CW-1:0];

   // reset leaves the block ready with no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (req_tready && !rsp_tvalid))
      else $error("block not idle after reset");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (count <= CW'(CAPACITY)))
      else $error("point count beyond capacity");

   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == ACT_CLEAR)) |-> (count == '0))
      else $error("clear did not empty the set");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == ACT_FULL)) |-> (count == CW'(CAPACITY)))
      else $error("drop reported while set not full");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result changed");

endmodule

bind point_toggle_proximity_set pts_checker #(
   .CAPACITY   (CAPACITY)
) u_pts_checker (.*);

`default_nettype wire

### tb/point_set_checker.sv
// checker for the point set: follows the req, rsp and csr channels and compares each result
`timescale 1ns / 100ps

module point_set_checker import pts_pkg::*; #(
   parameter int CAPACITY   = 256,
   parameter int COORD_BITS = 32,
   parameter int REQ_W      = ((3*COORD_BITS+7)/8)*8,
   parameter int RSP_W      = (($clog2(CAPACITY+1)+7)/8)*8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   input  wire logic                req_tready,
   // coord_x, coord_y, coord_z
   input  wire logic [REQ_W-1:0]    req_tdata,
   // mode
   input  wire logic [0:0]          req_tuser,
   input  wire logic                rsp_tvalid,
   input  wire logic                rsp_tready,
   // point_count
   input  wire logic [RSP_W-1:0]    rsp_tdata,
   // action
   input  wire logic [1:0]          rsp_tuser,
   input  wire logic                csr_valid,
   input  wire logic                csr_ready,
   input  wire logic [TOL_BITS-1:0] csr_data,
   output int                       err_count,
   output int                       pending
);

   localparam int CNT_W = $clog2(CAPACITY+1);

   typedef struct packed {
      logic signed [COORD_BITS-1:0] z;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] x;
   } point_t;

   typedef struct packed {
      action_type       action;
      logic [CNT_W-1:0] count;
   } outcome_t;

   point_t              stored_pts[$];
   outcome_t            outcomes_due[$];
   logic [TOL_BITS-1:0] radius = TOL_RESET;
   int                  errs = 0;

   // exact test in 64 bits: each axis first, then the sum of squares
   function automatic bit is_near(point_t a, point_t b);
      longint      dx, dy, dz;
      logic [63:0] ax, ay, az, r;
      dx = $signed(a.x) - $signed(b.x);
      dy = $signed(a.y) - $signed(b.y);
      dz = $signed(a.z) - $signed(b.z);
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      az = (dz < 0) ? -dz : dz;
      r  = radius;
      if (ax > r || ay > r || az > r) return 1'b0;
      return ax * ax + ay * ay + az * az <= r * r;
   endfunction

   function automatic outcome_t next_outcome(logic clear, point_t p);
      outcome_t o;
      int       hit;
      hit = -1;
      if (clear) begin
         stored_pts.delete();
         o.action = ACT_CLEAR;
      end else begin
         for (int i = 0; hit < 0 && i < stored_pts.size(); i++)
            if (is_near(stored_pts[i], p)) hit = i;
         if (hit >= 0) begin
            // later points move down one place
            stored_pts.delete(hit);
            o.action = ACT_REMOVE;
         end else if (stored_pts.size() >= CAPACITY) begin
            o.action = ACT_FULL;
         end else begin
            stored_pts.push_back(p);
            o.action = ACT_APPEND;
         end
      end
      o.count = CNT_W'(stored_pts.size());
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_t want;
      if (reset) begin
         stored_pts.delete();
         outcomes_due.delete();
         radius = TOL_RESET;
      end else begin
         if (csr_valid && csr_ready) radius = csr_data;
         // a result never belongs to an item taken at the same edge
         if (rsp_tvalid && rsp_tready) begin
            if (outcomes_due.size() == 0) begin
               if (errs < 10)
                  $display("%0t: result with no item outstanding: action %0d count %0d",
                           $time, rsp_tuser, rsp_tdata);
               errs++;
            end else begin
               want = outcomes_due.pop_front();
               if (rsp_tuser != want.action || rsp_tdata != RSP_W'(want.count)) begin
                  if (errs < 10)
                     $display("%0t: mismatch: expected action %0d count %0d, got action %0d count %0d",
                              $time, want.action, want.count, rsp_tuser, rsp_tdata);
                  errs++;
               end
            end
         end
         if (req_tvalid && req_tready)
            outcomes_due.push_back(next_outcome(req_tuser[0],
                                                point_t'(req_tdata[3*COORD_BITS-1:0])));
      end
      err_count <= errs;
      pending   <= outcomes_due.size();
   end

endmodule

### tb/tb_point_toggle_proximity_set.sv
// testbench top for the point set: drives items and tolerance writes, gives the verdict
`timescale 1ns / 100ps

module tb_point_toggle_proximity_set;
   import pts_pkg::*;

   localparam int CAPACITY      = 256;
   localparam int COORD_BITS    = 32;
   localparam int REQ_W         = ((3*COORD_BITS+7)/8)*8;
   localparam int RSP_W         = (($clog2(CAPACITY+1)+7)/8)*8;
   localparam int FILL_ITEMS    = CAPACITY + 6;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 160;
   localparam int RECENT_DEPTH  = 32;
   localparam logic MODE_TOGGLE = 1'b0;
   localparam logic MODE_CLEAR  = 1'b1;

   typedef logic signed [COORD_BITS-1:0] coord_t;

   typedef struct packed {
      coord_t z;
      coord_t y;
      coord_t x;
   } point_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tdata = '0;
   logic [0:0]          req_tuser = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_W-1:0]    rsp_tdata;
   logic [1:0]          rsp_tuser;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [TOL_BITS-1:0] csr_data = '0;
   int                  err_count;
   int                  pending;

   bit                  stalls_on = 1'b1;
   logic [TOL_BITS-1:0] cur_tol = TOL_RESET;
   point_t              recent[RECENT_DEPTH];
   int                  recent_n = 0;
   int                  recent_wr = 0;
   int                  rsp_hold = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   point_toggle_proximity_set #(
      .CAPACITY   (CAPACITY),
      .COORD_BITS (COORD_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   point_set_checker #(
      .CAPACITY   (CAPACITY),
      .COORD_BITS (COORD_BITS)
   ) watch (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .err_count  (err_count),
      .pending    (pending)
   );

   // result side: after each transfer hold tready low for a random number of cycles
   always @(posedge clock) begin
      int gap;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         gap = stalls_on ? $urandom_range(0, 15) : 0;
         rsp_hold   <= gap;
         rsp_tready <= (gap == 0);
      end else if (rsp_hold != 0) begin
         rsp_hold   <= rsp_hold - 1;
         rsp_tready <= (rsp_hold == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic point_t pt(coord_t x, coord_t y, coord_t z);
      point_t p;
      p.x = x;
      p.y = y;
      p.z = z;
      return p;
   endfunction

   function automatic coord_t pick_coord();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 9))
         0: begin
            case (r[1:0])
               2'd0: return {1'b0, {(COORD_BITS-1){1'b1}}};
               2'd1: return {1'b1, {(COORD_BITS-1){1'b0}}};
               2'd2: return '0;
               default: return '1;
            endcase
         end
         1, 2, 3, 4: return coord_t'({$urandom, $urandom});
         default: return coord_t'($signed(r[20:0]));
      endcase
   endfunction

   function automatic point_t pick_point();
      return pt(pick_coord(), pick_coord(), pick_coord());
   endfunction

   function automatic point_t spread_point();
      return pt(coord_t'({$urandom, $urandom}), coord_t'({$urandom, $urandom}),
                coord_t'({$urandom, $urandom}));
   endfunction

   function automatic coord_t nudge(coord_t c, logic [31:0] reach);
      coord_t d;
      d = coord_t'($urandom_range(0, reach));
      return $urandom_range(0, 1) ? c + d : c - d;
   endfunction

   // a point around an earlier one, mostly inside the radius, sometimes just past it
   function automatic point_t near_point(point_t base);
      logic [31:0] reach;
      case ($urandom_range(0, 3))
         0: reach = cur_tol / 2;
         1: reach = cur_tol / 4;
         2: reach = cur_tol;
         default: reach = cur_tol + cur_tol / 8 + 1;
      endcase
      return pt(nudge(base.x, reach), nudge(base.y, reach), nudge(base.z, reach));
   endfunction

   function automatic logic [TOL_BITS-1:0] pick_tolerance();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return TOL_RESET;
         3: return TOL_BITS'($urandom_range(1, 1 << 18));
         4: return TOL_BITS'($urandom);
         default: return TOL_BITS'($urandom_range(0, 1 << 22));
      endcase
   endfunction

   task automatic send_item(input logic mode, input point_t p);
      int gap;
      gap = stalls_on ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= REQ_W'(p);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (mode == MODE_TOGGLE) begin
         recent[recent_wr] = p;
         recent_wr = (recent_wr + 1) % RECENT_DEPTH;
         if (recent_n < RECENT_DEPTH) recent_n++;
      end
   endtask

   // stop sending and wait until every result is back
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_tolerance(input logic [TOL_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_tol = value;
   endtask

   task automatic random_item();
      int     r;
      point_t p;
      r = $urandom_range(0, 99);
      p = pick_point();
      if (r < 3)
         send_item(MODE_CLEAR, p);
      else if (r < 56 && recent_n > 0) begin
         p = recent[$urandom_range(0, recent_n - 1)];
         send_item(MODE_TOGGLE, (r < 48) ? near_point(p) : p);
      end else
         send_item(MODE_TOGGLE, p);
   endtask

   initial begin
      int ph;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // radius 1.0 after reset
      send_item(MODE_TOGGLE, pt(0, 0, 0));
      send_item(MODE_TOGGLE, pt(32'sh0001_0000, 0, 0));  // exactly on the radius
      send_item(MODE_TOGGLE, pt(0, 0, 0));
      send_item(MODE_TOGGLE, pt(32'sh0001_0001, 0, 0));  // one lsb past it
      send_item(MODE_TOGGLE, pt(-40000, -40000, -40000));  // axes inside, sum outside
      send_item(MODE_TOGGLE, pt(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
      send_item(MODE_TOGGLE, pt(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
      send_item(MODE_TOGGLE, pt(0, 0, 0));  // head removed, tail shifts
      send_item(MODE_TOGGLE, pt(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_0000));
      send_item(MODE_CLEAR, pt('1, '1, '1));
      send_item(MODE_CLEAR, pt(0, 0, 0));
      settle();

      // zero radius: only identical points match
      write_tolerance('0);
      send_item(MODE_TOGGLE, pt(5, 5, 5));
      send_item(MODE_TOGGLE, pt(5, 5, 6));
      send_item(MODE_TOGGLE, pt(5, 5, 5));
      send_item(MODE_TOGGLE, pt(5, 5, 6));
      settle();

      // widest radius against the coordinate extremes
      write_tolerance('1);
      send_item(MODE_TOGGLE, pt(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
      send_item(MODE_TOGGLE, pt(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
      send_item(MODE_TOGGLE, pt(0, 0, 0));
      send_item(MODE_TOGGLE, pt(1, 0, 0));
      send_item(MODE_TOGGLE, pt(32'sh7fff_ffff, 0, 0));
      send_item(MODE_CLEAR, pt(0, 0, 0));
      settle();

      // fill past capacity, then toggle while full
      write_tolerance(TOL_RESET);
      send_item(MODE_CLEAR, pt(0, 0, 0));
      for (int i = 0; i < FILL_ITEMS; i++) send_item(MODE_TOGGLE, spread_point());
      for (int i = 0; i < 24; i++) random_item();

      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         settle();
         write_tolerance(pick_tolerance());
         stalls_on = (ph % 3 != 1);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(0, 99) == 0) settle();
            random_item();
         end
      end

      settle();
      repeat (20) @(posedge clock);
      if (err_count == 0 && pending == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
